// File: hdl/gtg_pkg.sv
// Shared types, constants and the arctangent table for the go-to-goal controller.
`timescale 1ns / 1ps

package gtg_pkg;

    // Field widths
    localparam int POS_WIDTH         = 24;
    localparam int ANGLE_WIDTH       = 16;
    localparam int GAIN_W            = 16;
    localparam int LIN_W             = POS_WIDTH - 1;
    localparam int ANG_W             = ANGLE_WIDTH + 8;
    localparam int CFG_W             = LIN_W;
    localparam int CFG_IDX_W         = 2;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_TABLE_LEN    = 24;

    // CORDIC datapath
    localparam int    GUARD_BITS = 4;
    localparam int    ZW         = 32;
    localparam logic [23:0] INV_GAIN = 24'h9B74EE;   // 1/K in Q0.24

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_TOLERANCE = 2'd2;

    // Register reset values
    localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST    = 16'd256;
    localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST   = 16'd256;
    localparam logic [LIN_W-1:0]  GOAL_TOLERANCE_RST = 23'd410;

    // Pose and goal, one input transfer
    typedef struct packed {
        logic signed [POS_WIDTH-1:0]   cur_x;
        logic signed [POS_WIDTH-1:0]   cur_y;
        logic signed [ANGLE_WIDTH-1:0] cur_heading;
        logic signed [POS_WIDTH-1:0]   goal_x;
        logic signed [POS_WIDTH-1:0]   goal_y;
    } t_in;

    // Speed command, one output transfer
    typedef struct packed {
        logic [LIN_W-1:0]        linear_speed;
        logic signed [ANG_W-1:0] angular_speed;
        logic                    at_goal;
    } t_out;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic [ZW-1:0] atan_turn(input int idx);
        logic [ZW-1:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/go_to_goal_p_controller_unit.sv
// Go-to-goal proportional controller: pipelined CORDIC vectoring plus gain stages.
`timescale 1ns / 1ps

// Takes one pose/goal transfer per clock while o_in_ready is high and returns one speed
// command per pose, in order. The stages are pre-rotation, one register per CORDIC
// iteration, the 1/K multiply, distance/bearing, gain multiplies and a saturating output
// register. A stage holds its item only while the next is full and stalled, so the input
// keeps accepting until every stage is full. The user writes gains and tolerance through
// the register port only while the pipeline is empty; the block does not enforce this.
module go_to_goal_p_controller_unit #(
    parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  gtg_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output gtg_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_we,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gtg_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import gtg_pkg::*;

    localparam int XW     = 32;                    // CORDIC x/y width, holds K*sqrt(2)*2^28
    localparam int NS     = CORDIC_STAGES + 5;     // total pipeline stages
    localparam int S_MUL  = CORDIC_STAGES + 1;
    localparam int S_DIST = CORDIC_STAGES + 2;
    localparam int S_GAIN = CORDIC_STAGES + 3;
    localparam int S_OUT  = CORDIC_STAGES + 4;
    localparam int PROD_W = XW - 1 + 24;           // clamped x times 1/K
    localparam int DIST_W = PROD_W - 28;
    localparam int LINP_W = DIST_W + GAIN_W;
    localparam int ANGP_W = ANGLE_WIDTH + GAIN_W + 1;

    typedef struct packed {
        logic signed [XW-1:0]          x;
        logic signed [XW-1:0]          y;
        logic [ZW-1:0]                 z;
        logic signed [ANGLE_WIDTH-1:0] heading;
        logic                          zero;
    } t_cordic;

    // Configuration registers
    logic [GAIN_W-1:0] r_lin_gain;
    logic [GAIN_W-1:0] r_ang_gain;
    logic [LIN_W-1:0]  r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_gain <= LINEAR_GAIN_RST;
            r_ang_gain <= ANGULAR_GAIN_RST;
            r_tol      <= GOAL_TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LINEAR_GAIN:    r_lin_gain <= i_cfg_wdata[GAIN_W-1:0];
                REG_ANGULAR_GAIN:   r_ang_gain <= i_cfg_wdata[GAIN_W-1:0];
                REG_GOAL_TOLERANCE: r_tol      <= i_cfg_wdata[LIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits and per-stage advance
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;
    logic [NS-1:0] w_vin;
    logic [NS-1:0] w_ld;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign w_vin = {r_v[NS-2:0], i_in_valid};
    assign w_ld  = w_en & w_vin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[S_OUT];

    // Stage 0: differences and pre-rotation into the right half plane
    t_cordic r_cs [0:CORDIC_STAGES];

    logic signed [POS_WIDTH:0] w_dx;
    logic signed [POS_WIDTH:0] w_dy;
    logic signed [POS_WIDTH:0] w_ndx;
    logic signed [POS_WIDTH:0] w_ndy;
    t_cordic                   n_cs0;

    assign w_dx  = $signed({i_in_data.goal_x[POS_WIDTH-1], i_in_data.goal_x})
                 - $signed({i_in_data.cur_x[POS_WIDTH-1], i_in_data.cur_x});
    assign w_dy  = $signed({i_in_data.goal_y[POS_WIDTH-1], i_in_data.goal_y})
                 - $signed({i_in_data.cur_y[POS_WIDTH-1], i_in_data.cur_y});
    assign w_ndx = $signed({i_in_data.cur_x[POS_WIDTH-1], i_in_data.cur_x})
                 - $signed({i_in_data.goal_x[POS_WIDTH-1], i_in_data.goal_x});
    assign w_ndy = $signed({i_in_data.cur_y[POS_WIDTH-1], i_in_data.cur_y})
                 - $signed({i_in_data.goal_y[POS_WIDTH-1], i_in_data.goal_y});

    always_comb begin
        n_cs0.heading = i_in_data.cur_heading;
        n_cs0.zero    = (w_dx == '0) && (w_dy == '0);
        if (w_dx[POS_WIDTH]) begin
            n_cs0.x = XW'(w_ndx) <<< GUARD_BITS;
            n_cs0.y = XW'(w_ndy) <<< GUARD_BITS;
            n_cs0.z = {1'b1, {(ZW-1){1'b0}}};      // half turn
        end else begin
            n_cs0.x = XW'(w_dx) <<< GUARD_BITS;
            n_cs0.y = XW'(w_dy) <<< GUARD_BITS;
            n_cs0.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_cs[0] <= n_cs0;
        end
    end

    // CORDIC vectoring, one iteration per stage
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        localparam logic [ZW-1:0] ATAN = atan_turn(k);
        t_cordic n_cs;

        always_comb begin
            n_cs = r_cs[k];
            if (!r_cs[k].y[XW-1]) begin
                n_cs.x = r_cs[k].x + (r_cs[k].y >>> k);
                n_cs.y = r_cs[k].y - (r_cs[k].x >>> k);
                n_cs.z = r_cs[k].z + ATAN;
            end else begin
                n_cs.x = r_cs[k].x - (r_cs[k].y >>> k);
                n_cs.y = r_cs[k].y + (r_cs[k].x >>> k);
                n_cs.z = r_cs[k].z - ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ld[k+1]) begin
                r_cs[k+1] <= n_cs;
            end
        end
    end

    // Magnitude times 1/K
    logic [XW-2:0]                 w_xpos;
    logic [PROD_W-1:0]             r_prod;
    logic [ZW-1:0]                 r_mz;
    logic signed [ANGLE_WIDTH-1:0] r_mhd;
    logic                          r_mzero;

    assign w_xpos = r_cs[CORDIC_STAGES].x[XW-1] ? '0 : r_cs[CORDIC_STAGES].x[XW-2:0];

    always_ff @(posedge i_clk) begin
        if (w_ld[S_MUL]) begin
            r_prod  <= PROD_W'(w_xpos) * PROD_W'(INV_GAIN);
            r_mz    <= r_cs[CORDIC_STAGES].z;
            r_mhd   <= r_cs[CORDIC_STAGES].heading;
            r_mzero <= r_cs[CORDIC_STAGES].zero;
        end
    end

    // Rounded distance, tolerance check, heading error
    logic [PROD_W-1:0]             w_rsum;
    logic [DIST_W-1:0]             w_dist;
    logic [ZW-1:0]                 w_zr;
    logic [ANGLE_WIDTH-1:0]        w_bear;
    logic [DIST_W-1:0]             r_dist;
    logic signed [ANGLE_WIDTH-1:0] r_err;
    logic                          r_atg_d;

    assign w_rsum = r_prod + (PROD_W'(1) << 27);
    assign w_dist = w_rsum[PROD_W-1:28];
    assign w_zr   = r_mz + (ZW'(1) << (ZW - 1 - ANGLE_WIDTH));
    assign w_bear = r_mzero ? '0 : w_zr[ZW-1 -: ANGLE_WIDTH];

    always_ff @(posedge i_clk) begin
        if (w_ld[S_DIST]) begin
            r_dist  <= w_dist;
            r_err   <= $signed(w_bear - r_mhd);
            r_atg_d <= w_dist < DIST_W'(r_tol);
        end
    end

    // Gain multiplies
    logic signed [ANGP_W-1:0] w_errx;
    logic signed [ANGP_W-1:0] w_gainx;
    logic [LINP_W-1:0]        r_linp;
    logic signed [ANGP_W-1:0] r_angp;
    logic                     r_atg_g;

    assign w_errx  = ANGP_W'(r_err);
    assign w_gainx = ANGP_W'($signed({1'b0, r_ang_gain}));

    always_ff @(posedge i_clk) begin
        if (w_ld[S_GAIN]) begin
            r_linp  <= LINP_W'(r_dist) * LINP_W'(r_lin_gain);
            r_angp  <= w_errx * w_gainx;
            r_atg_g <= r_atg_d;
        end
    end

    // Scale by 1/256, saturate, zero at goal
    logic [LINP_W-9:0] w_lin_hi;
    logic [ANG_W:0]    w_ang;
    t_out              n_out;
    t_out              r_out;

    assign w_lin_hi = r_linp[LINP_W-1:8];
    assign w_ang    = r_angp[ANGP_W-1:8];

    always_comb begin
        n_out.at_goal = r_atg_g;
        if (|w_lin_hi[LINP_W-9:LIN_W]) begin
            n_out.linear_speed = '1;
        end else begin
            n_out.linear_speed = w_lin_hi[LIN_W-1:0];
        end
        if (w_ang[ANG_W] != w_ang[ANG_W-1]) begin
            n_out.angular_speed = {w_ang[ANG_W], {(ANG_W-1){~w_ang[ANG_W]}}};
        end else begin
            n_out.angular_speed = w_ang[ANG_W-1:0];
        end
        if (r_atg_g) begin
            n_out.linear_speed  = '0;
            n_out.angular_speed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[S_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule
